@@ sv/fpr_pkg.sv @@
// Shared constants, types, and the command and result structs for the FIFO page replacement core.
`default_nettype none
package fpr_pkg;

  localparam int FRAMES = 10;
  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam int ADDR_W  = 16;
  localparam int PAGE_W  = 13;
  localparam int FRAME_W = 6;
  localparam int FREE_W  = 7;
  localparam int COUNT_W = 16;

  localparam int PROD_W      = 33;
  localparam int RECIP_SHIFT = 19;
  localparam logic [PROD_W-1:0] PAGE_RECIP = PROD_W'(52429);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic load_addr;
    logic load_page;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
  } result_t;

endpackage
`default_nettype wire

@@ sv/fpr_if.sv @@
// Valid/ready channel interfaces for the address input and the lookup result.
`default_nettype none
interface fpr_in_if;
  logic                       valid;
  logic                       ready;
  logic [fpr_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface fpr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [fpr_pkg::PAGE_W-1:0]  page_number;
  logic [fpr_pkg::FRAME_W-1:0] frame_index;
  logic                        evicted_valid;
  logic [fpr_pkg::PAGE_W-1:0]  evicted_page;
  logic [fpr_pkg::COUNT_W-1:0] fault_count;

  modport source (output valid, output hit, output page_number, output frame_index,
                  output evicted_valid, output evicted_page, output fault_count,
                  input ready);
  modport sink (input valid, input hit, input page_number, input frame_index,
                input evicted_valid, input evicted_page, input fault_count,
                output ready);
endinterface
`default_nettype wire

@@ sv/fifo_page_replacement_core.sv @@
// Top level of the FIFO page replacement core: controller, datapath and channel ports.
// Usage:
//   in_ch carries one instruction address per beat; out_ch returns one result beat per
//   address: hit flag, page number (address / 10), frame index, eviction flag and page,
//   and the saturating fault count.
//   An address beat passes the address register, the page register and then the result
//   register, whose output is the result beat.
//   The divide by the page size and the parallel compare over all frames are each
//   a registered step in the datapath, and the controller takes one address at a time;
//   no new address is taken until the last one is committed to the result register.
//   The next address is taken while a finished result still waits in the output
//   register. If the receiver stalls, the lookup holds until the output register
//   frees, and in_ch.ready stays low meanwhile.
//   Reset (rst_n low, synchronous) empties every frame, sets the free count to the
//   number of frames, the replacement pointer to frame zero and the fault count to
//   zero, and drops any pending result. No clearing pass follows reset.
`default_nettype none
module fifo_page_replacement_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fpr_in_if.sink      in_ch,
  fpr_out_if.source   out_ch
);

  fpr_pkg::dp_cmd_t cmd;
  fpr_pkg::result_t res;

  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  fpr_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .addr_in (in_ch.address),
    .res     (res)
  );

  assign out_ch.hit           = res.hit;
  assign out_ch.page_number   = res.page_number;
  assign out_ch.frame_index   = res.frame_index;
  assign out_ch.evicted_valid = res.evicted_valid;
  assign out_ch.evicted_page  = res.evicted_page;
  assign out_ch.fault_count   = res.fault_count;

endmodule
`default_nettype wire

@@ sv/fpr_ctrl.sv @@
// Controller state machine: sequences divide, lookup and result hand-off.
`default_nettype none
module fpr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fpr_pkg::dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_LOOK
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load_addr = (state_r == S_IDLE) && in_valid;
    cmd.load_page = (state_r == S_DIV);
    cmd.commit    = (state_r == S_LOOK) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_LOOK;
        end
        S_LOOK: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/fpr_dpath.sv @@
// Datapath: page divide, frame table, parallel lookup, replacement and result register.
`default_nettype none
module fpr_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fpr_pkg::dp_cmd_t           cmd,
  input  wire logic [fpr_pkg::ADDR_W-1:0] addr_in,
  output fpr_pkg::result_t                res
);

  logic [fpr_pkg::ADDR_W-1:0]  addr_r;
  logic [fpr_pkg::PAGE_W-1:0]  page_r;
  logic [fpr_pkg::PAGE_W-1:0]  frame_page_r [fpr_pkg::FRAMES];
  logic [fpr_pkg::FRAMES-1:0]  frame_valid_r;
  logic [fpr_pkg::FREE_W-1:0]  free_r;
  logic [fpr_pkg::FRAME_W-1:0] ptr_r;
  logic [fpr_pkg::COUNT_W-1:0] faults_r;
  fpr_pkg::result_t            res_r;

  logic [fpr_pkg::PROD_W-1:0]  prod;
  logic                        hit_any;
  logic [fpr_pkg::FRAME_W-1:0] hit_idx;
  logic                        free_any;
  logic [fpr_pkg::FRAME_W-1:0] free_idx;
  logic [fpr_pkg::FRAME_W-1:0] ptr_eff;
  logic [fpr_pkg::FREE_W-1:0]  ptr_inc;
  logic [fpr_pkg::FRAME_W-1:0] ptr_nxt;
  logic                        use_free;
  logic [fpr_pkg::FRAME_W-1:0] slot;
  logic [fpr_pkg::FIDX_W-1:0]  slot_a;
  logic [fpr_pkg::FIDX_W-1:0]  ptr_a;
  logic [fpr_pkg::COUNT_W-1:0] faults_nxt;

  assign prod = {{(fpr_pkg::PROD_W - fpr_pkg::ADDR_W){1'b0}}, addr_r} * fpr_pkg::PAGE_RECIP;

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = fpr_pkg::FRAMES - 1; i >= 0; i--) begin
      if (frame_valid_r[i] && (frame_page_r[i] == page_r)) begin
        hit_any = 1'b1;
        hit_idx = fpr_pkg::FRAME_W'(i);
      end
      if (!frame_valid_r[i]) begin
        free_any = 1'b1;
        free_idx = fpr_pkg::FRAME_W'(i);
      end
    end
  end

  always_comb begin
    ptr_eff    = ({1'b0, ptr_r} < fpr_pkg::FREE_W'(fpr_pkg::FRAMES)) ? ptr_r : '0;
    ptr_inc    = {1'b0, ptr_eff} + fpr_pkg::FREE_W'(1);
    ptr_nxt    = (ptr_inc >= fpr_pkg::FREE_W'(fpr_pkg::FRAMES)) ? '0
                 : ptr_inc[fpr_pkg::FRAME_W-1:0];
    use_free   = (free_r != '0) && free_any;
    slot       = use_free ? free_idx : ptr_eff;
    slot_a     = slot[fpr_pkg::FIDX_W-1:0];
    ptr_a      = ptr_eff[fpr_pkg::FIDX_W-1:0];
    faults_nxt = (faults_r == fpr_pkg::COUNT_MAX) ? faults_r
                 : faults_r + fpr_pkg::COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_addr) begin
      addr_r <= addr_in;
    end
    if (cmd.load_page) begin
      page_r <= prod[fpr_pkg::RECIP_SHIFT +: fpr_pkg::PAGE_W];
    end
    if (cmd.commit && !hit_any) begin
      frame_page_r[slot_a] <= page_r;
    end
    if (cmd.commit) begin
      res_r.page_number <= page_r;
      if (hit_any) begin
        res_r.hit           <= 1'b1;
        res_r.frame_index   <= hit_idx;
        res_r.evicted_valid <= 1'b0;
        res_r.evicted_page  <= '0;
        res_r.fault_count   <= faults_r;
      end else begin
        res_r.hit           <= 1'b0;
        res_r.frame_index   <= slot;
        res_r.evicted_valid <= !use_free;
        res_r.evicted_page  <= use_free ? '0 : frame_page_r[ptr_a];
        res_r.fault_count   <= faults_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      free_r        <= fpr_pkg::FREE_W'(fpr_pkg::FRAMES);
      ptr_r         <= '0;
      faults_r      <= '0;
    end else if (cmd.commit && !hit_any) begin
      faults_r              <= faults_nxt;
      frame_valid_r[slot_a] <= 1'b1;
      if (use_free) begin
        free_r <= free_r - fpr_pkg::FREE_W'(1);
      end else begin
        free_r <= '0;
        ptr_r  <= ptr_nxt;
      end
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire
